// ===== rtl/rsd_pkg.sv =====
// Shared types and constants for the signed restoring divider.
`timescale 1ns / 1ps
package rsd_pkg;

  localparam int DW = 32;

  typedef struct packed {
    logic signed [DW-1:0] dividend;
    logic signed [DW-1:0] divisor;
  } div_in_t;

  typedef struct packed {
    logic signed [DW-1:0] quotient;
    logic signed [DW-1:0] remainder;
    logic                 divide_by_zero;
  } div_out_t;

  // One word in flight through the cell row.
  // nq holds the dividend bits not yet consumed at the top and the
  // quotient bits built so far at the bottom.
  typedef struct packed {
    logic [DW-1:0] acc;
    logic [DW-1:0] nq;
    logic [DW-1:0] dv;
    logic          neg_a;
    logic          neg_b;
    logic          dbz;
  } stage_t;

  localparam logic [DW-1:0] Q_MAX = {1'b0, {(DW-1){1'b1}}};

endpackage

// ===== rtl/rsd_prep.sv =====
// Front stage: takes operand magnitudes and signs and registers them.
`timescale 1ns / 1ps
module rsd_prep import rsd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    up_valid,
  output logic    up_ready,
  input  div_in_t up,
  output logic    dn_valid,
  input  logic    dn_ready,
  output stage_t  dn
);

  stage_t dn_next;
  logic   a_neg, b_neg;

  assign a_neg    = up.dividend[DW-1];
  assign b_neg    = up.divisor[DW-1];
  assign up_ready = !dn_valid || dn_ready;

  always_comb begin
    dn_next.acc   = '0;
    dn_next.nq    = a_neg ? DW'(-up.dividend) : DW'(up.dividend);
    dn_next.dv    = b_neg ? DW'(-up.divisor) : DW'(up.divisor);
    dn_next.neg_a = a_neg;
    dn_next.neg_b = b_neg;
    dn_next.dbz   = (up.divisor == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn <= dn_next;
    end
  end

endmodule

// ===== rtl/rsd_cell.sv =====
// One restoring step: shift in a dividend bit, trial subtract, keep or restore.
`timescale 1ns / 1ps
module rsd_cell import rsd_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   up_valid,
  output logic   up_ready,
  input  stage_t up,
  output logic   dn_valid,
  input  logic   dn_ready,
  output stage_t dn
);

  stage_t      dn_next;
  logic [DW:0] shifted;
  logic [DW:0] diff;
  logic        fits;

  assign up_ready = !dn_valid || dn_ready;
  assign shifted  = {up.acc, up.nq[DW-1]};
  assign diff     = shifted - {1'b0, up.dv};
  assign fits     = !diff[DW];

  always_comb begin
    dn_next     = up;
    dn_next.acc = fits ? diff[DW-1:0] : shifted[DW-1:0];
    dn_next.nq  = {up.nq[DW-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn <= dn_next;
    end
  end

endmodule

// ===== rtl/rsd_post.sv =====
// Back stage: applies signs, saturation and divide-by-zero, output register.
`timescale 1ns / 1ps
module rsd_post import rsd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     up_valid,
  output logic     up_ready,
  input  stage_t   up,
  output logic     dn_valid,
  input  logic     dn_ready,
  output div_out_t dn
);

  div_out_t      dn_next;
  logic [DW-1:0] q_mag, r_mag;

  assign q_mag    = up.nq;
  assign r_mag    = up.acc;
  assign up_ready = !dn_valid || dn_ready;

  always_comb begin
    dn_next.divide_by_zero = up.dbz;
    if (up.dbz) begin
      dn_next.quotient  = '0;
      dn_next.remainder = '0;
    end else begin
      if (up.neg_a != up.neg_b) begin
        dn_next.quotient = -q_mag;
      end else if (q_mag[DW-1]) begin
        // most negative over minus one
        dn_next.quotient = Q_MAX;
      end else begin
        dn_next.quotient = q_mag;
      end
      dn_next.remainder = up.neg_a ? -r_mag : r_mag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn <= dn_next;
    end
  end

endmodule

// ===== rtl/restoring_signed_divider.sv =====
// An accepted word passes the prep register, 32 cell registers and the post register.
// One word per cycle unless stalled; each of 32 cells does one trial subtract.
// Stages hold independently, so bubbles in the row are absorbed under backpressure.
// Reset (rst, synchronous, active high) clears all stage valid bits.
`timescale 1ns / 1ps
module restoring_signed_divider import rsd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  div_in_t  req,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output div_out_t rsp
);

  stage_t st  [DW+1];
  logic   vld [DW+1];
  logic   rdy [DW+1];

  rsd_prep u_prep (
    .clk      (clk),
    .rst      (rst),
    .up_valid (req_valid),
    .up_ready (req_ready),
    .up       (req),
    .dn_valid (vld[0]),
    .dn_ready (rdy[0]),
    .dn       (st[0])
  );

  for (genvar k = 0; k < DW; k++) begin : g_cell
    rsd_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (vld[k]),
      .up_ready (rdy[k]),
      .up       (st[k]),
      .dn_valid (vld[k+1]),
      .dn_ready (rdy[k+1]),
      .dn       (st[k+1])
    );
  end

  rsd_post u_post (
    .clk      (clk),
    .rst      (rst),
    .up_valid (vld[DW]),
    .up_ready (rdy[DW]),
    .up       (st[DW]),
    .dn_valid (rsp_valid),
    .dn_ready (rsp_ready),
    .dn       (rsp)
  );

endmodule

// ===== rtl/rsd_checker.sv =====
// Port-level assertions for the signed restoring divider, bound to the top.
`timescale 1ns / 1ps
module rsd_checker import rsd_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     req_valid,
  input logic     req_ready,
  input div_in_t  req,
  input logic     rsp_valid,
  input logic     rsp_ready,
  input div_out_t rsp
);

  // result word held while stalled
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result word changed under backpressure");

  a_dbz_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.divide_by_zero |-> rsp.quotient == '0 && rsp.remainder == '0)
    else $error("divide by zero with nonzero results");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("result valid right after reset");

  // an empty output register means every stage can move
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> req_ready)
    else $error("input stalled while output register empty");

endmodule

bind restoring_signed_divider rsd_checker u_rsd_checker (.*);
